// ----- hw/rtl/csvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvs_pkg
// shared types and constants of the csv record field splitter
// ----------------------------------------------------------------------------
package csvs_pkg;

  localparam int MAX_RECORD_BYTES = 4096;
  localparam int MAX_FIELDS       = 32;

  // record positions hold 0 .. MAX_RECORD_BYTES, hence one bit more than the field width
  localparam int POS_W   = $clog2(MAX_RECORD_BYTES);
  localparam int OFS_W   = POS_W + 1;
  localparam int CNT_W   = 6;
  localparam int SLOT_W  = 6;
  localparam int FNUM_W  = 5;
  localparam int STAT_W  = 2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OPEN_QT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic              write_valid;
    logic [11:0]       write_position;
    logic [7:0]        write_data;
    logic              field_valid;
    logic [FNUM_W-1:0] field_number;
    logic [11:0]       field_offset;
    logic [11:0]       field_length;
    logic              record_done;
    logic [CNT_W-1:0]  fields_in_record;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

// ----- hw/rtl/csvs_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvs_in_stage
// input register: holds one item until the parser takes it
// ----------------------------------------------------------------------------
module csvs_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tuser,
  input  logic           take,
  output logic           item_valid,
  output csvs_pkg::item_t item
);
  import csvs_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data_byte    <= in_tdata;
      item_r.end_of_input <= in_tuser;
    end
  end

endmodule

// ----- hw/rtl/csvs_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvs_parse
// per-record parse state and the single-pass step logic for one item
// ----------------------------------------------------------------------------
module csvs_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [csvs_pkg::SLOT_W-1:0]   cfg_wr_data,
  input  logic                          step,
  input  csvs_pkg::item_t               item,
  output csvs_pkg::result_t             res
);
  import csvs_pkg::*;

  logic [SLOT_W-1:0] field_slots_r;

  logic             acr_r, acr_nxt;
  logic             aq_r, aq_nxt;
  logic             inq_r, inq_nxt;
  logic             fb_r, fb_nxt;
  logic [OFS_W-1:0] begin_r, begin_nxt;
  logic             es_r, es_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic [OFS_W-1:0] shift_r, shift_nxt;
  logic [OFS_W-1:0] bo_r, bo_nxt;
  logic [CNT_W-1:0] fc_r;
  logic [CNT_W-1:0] fc_nxt;

  logic [SLOT_W-1:0] slots_eff;
  logic [OFS_W-1:0]  here;
  logic [OFS_W-1:0]  pos_full;
  logic [POS_W-1:0]  pos;
  logic              aq_l;
  logic              do_emit;
  logic [OFS_W-1:0]  emit_b;
  logic [OFS_W-1:0]  emit_e;
  logic [OFS_W-1:0]  emit_len;
  logic              clear;
  logic [7:0]        c;

  assign slots_eff = (field_slots_r > SLOT_W'(MAX_FIELDS)) ? SLOT_W'(MAX_FIELDS)
                                                           : field_slots_r;
  assign c    = item.data_byte;
  assign here = bo_r - shift_r;

  always_comb begin
    acr_nxt   = acr_r;
    aq_nxt    = aq_r;
    inq_nxt   = inq_r;
    fb_nxt    = fb_r;
    begin_nxt = begin_r;
    es_nxt    = es_r;
    end_nxt   = end_r;
    shift_nxt = shift_r;
    bo_nxt    = bo_r;
    do_emit   = 1'b0;
    emit_b    = '0;
    emit_e    = '0;
    clear     = 1'b0;
    aq_l      = aq_r;
    pos_full  = '0;
    pos       = '0;
    res       = '0;

    if (item.end_of_input) begin
      if (inq_r && !es_r) begin
        res.status = STAT_OPEN_QT;
      end else if (bo_r != '0) begin
        do_emit = 1'b1;
        emit_b  = fb_r ? begin_r : here;
        emit_e  = es_r ? OFS_W'(end_r) : here;
      end
      res.record_done = 1'b1;
      clear = 1'b1;
    end else if (bo_r >= OFS_W'(MAX_RECORD_BYTES)) begin
      // byte dropped, record closed without a field
      res.record_done = 1'b1;
      res.status      = STAT_OVERFLOW;
      clear = 1'b1;
    end else begin
      if ((acr_r && c == CH_LF) || (aq_r && c == CH_QUOTE)) begin
        shift_nxt = shift_r + OFS_W'(1);
      end
      pos_full = bo_r - shift_nxt;
      pos      = pos_full[POS_W-1:0];
      if (shift_nxt != '0) begin
        res.write_valid    = 1'b1;
        res.write_position = 12'(pos);
        res.write_data     = c;
      end
      if (!fb_r && c != CH_SPACE) begin
        inq_nxt   = (c == CH_QUOTE);
        aq_l      = inq_nxt;
        begin_nxt = OFS_W'(pos) + OFS_W'(inq_nxt);
        fb_nxt    = 1'b1;
      end
      if (fb_nxt && !es_r &&
          ((!inq_nxt && (c == CH_SPACE || c == CH_COMMA || c == CH_LF)) ||
           (inq_nxt && !aq_l && c == CH_QUOTE))) begin
        end_nxt = pos;
        es_nxt  = 1'b1;
      end else if (es_r && c != CH_SPACE && c != CH_COMMA &&
                   c != CH_CR && c != CH_LF) begin
        es_nxt = 1'b0;
      end
      acr_nxt = (c == CH_CR);
      aq_nxt  = inq_nxt && !aq_l && (c == CH_QUOTE);
      bo_nxt  = bo_r + OFS_W'(1);

      if (es_nxt && c == CH_COMMA) begin
        do_emit   = 1'b1;
        emit_b    = begin_nxt;
        emit_e    = OFS_W'(end_nxt);
        shift_nxt = '0;
        fb_nxt    = 1'b0;
        es_nxt    = 1'b0;
        inq_nxt   = 1'b0;
      end else if (es_nxt && c == CH_LF) begin
        do_emit = 1'b1;
        emit_b  = begin_nxt;
        emit_e  = OFS_W'(end_nxt);
        res.record_done = 1'b1;
        clear = 1'b1;
      end
    end

    // field descriptor and running count
    emit_len = (emit_e >= emit_b) ? (emit_e - emit_b) : '0;
    fc_nxt   = fc_r;
    if (do_emit) begin
      if (fc_r < slots_eff) begin
        res.field_valid  = 1'b1;
        res.field_number = fc_r[FNUM_W-1:0];
        res.field_offset = emit_b[11:0];
        res.field_length = emit_len[11:0];
      end
      if (fc_r != '1) begin
        fc_nxt = fc_r + CNT_W'(1);
      end
    end
    res.fields_in_record = fc_nxt;

    if (clear) begin
      acr_nxt   = 1'b0;
      aq_nxt    = 1'b0;
      inq_nxt   = 1'b0;
      fb_nxt    = 1'b0;
      begin_nxt = '0;
      es_nxt    = 1'b0;
      end_nxt   = '0;
      shift_nxt = '0;
      bo_nxt    = '0;
      fc_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_slots_r <= SLOT_W'(MAX_FIELDS);
      acr_r   <= 1'b0;
      aq_r    <= 1'b0;
      inq_r   <= 1'b0;
      fb_r    <= 1'b0;
      begin_r <= '0;
      es_r    <= 1'b0;
      end_r   <= '0;
      shift_r <= '0;
      bo_r    <= '0;
      fc_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        field_slots_r <= cfg_wr_data;
      end
      if (step) begin
        acr_r   <= acr_nxt;
        aq_r    <= aq_nxt;
        inq_r   <= inq_nxt;
        fb_r    <= fb_nxt;
        begin_r <= begin_nxt;
        es_r    <= es_nxt;
        end_r   <= end_nxt;
        shift_r <= shift_nxt;
        bo_r    <= bo_nxt;
        fc_r    <= fc_nxt;
      end
    end
  end

  // collapsed bytes never outnumber the bytes held
  a_shift_le_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    shift_r <= bo_r)
    else $error("shift count exceeds record byte count");

  // a record end leaves the parse state clean
  a_clear_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.record_done |=> bo_r == '0 && fc_r == '0 && !inq_r && !fb_r)
    else $error("record state not cleared after record end");

  // the record never holds more than the buffer size
  a_bo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bo_r <= OFS_W'(MAX_RECORD_BYTES))
    else $error("record byte count beyond buffer size");

  // a descriptor always lies inside the accepted slots
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res.field_valid |-> (SLOT_W'(res.field_number) < slots_eff))
    else $error("field descriptor beyond configured slots");

endmodule

// ----- hw/rtl/csvs_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvs_out_stage
// result register toward the master-side channel
// ----------------------------------------------------------------------------
module csvs_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  csvs_pkg::result_t res,
  output logic              load,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);
  import csvs_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign load       = res_valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tlast  = res_r.record_done;
  assign out_tuser  = {res_r.field_valid, res_r.write_valid};
  assign out_tdata  = {7'd0, res_r.status, res_r.fields_in_record, res_r.field_length,
                       res_r.field_offset, res_r.field_number, res_r.write_data,
                       res_r.write_position};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ----- hw/rtl/csv_record_field_splitter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_record_field_splitter_unit
// splits a byte stream of csv records into field descriptors
// ----------------------------------------------------------------------------
// One byte (or an end-of-input marker) goes in per item and exactly one result
// item comes out for it, in order. The unit takes one item every clock cycle
// when the output side keeps up; each item passes through the input
// register and then the result register, and the parse state is updated
// once per item in the single step between them. Spaces around fields are
// trimmed, quotes stripped, doubled quotes and CR LF collapsed (the moved
// bytes come out as writes), and each finished field gives its offset and
// length while the slot count allows. There is no clearing pass after reset.
// Users must write field_slots via cfg_wr_en/cfg_wr_data while idle; not checked.
// ----------------------------------------------------------------------------
module csv_record_field_splitter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // field_slots register
  input  logic                        cfg_wr_en,
  input  logic [csvs_pkg::SLOT_W-1:0] cfg_wr_data,
  // input channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // data_byte
  input  logic                        in_tuser,   // end_of_input
  // result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // write_position[11:0], write_data[19:12], field_number[24:20],
  // field_offset[36:25], field_length[48:37], fields_in_record[54:49],
  // status[56:55], zero fill [63:57]
  output logic [63:0]                 out_tdata,
  output logic [1:0]                  out_tuser,  // field_valid[1], write_valid[0]
  output logic                        out_tlast   // record_done
);
  import csvs_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    load;
  result_t res;

  // input register; it frees up whenever its item moves to the result register
  csvs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (load),
    .item_valid (item_valid),
    .item       (item)
  );

  // parse step: state advances exactly when the result is loaded
  csvs_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (load),
    .item        (item),
    .res         (res)
  );

  // result register toward the consumer
  csvs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (item_valid),
    .res        (res),
    .load       (load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
